// ----- rtl/amd_pkg.sv -----
`timescale 1ns / 1ps
package amd_pkg;

  // one input word: upper three rows of the matrix, Q16.16
  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m03;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m13;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] m23;
  } in_t;

  // one result word
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic        [30:0] scale_y;
    logic        [30:0] scale_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] rot_w;
  } out_t;

  // queued job: matrix plus all-zero column flags
  typedef struct packed {
    in_t        mat;
    logic [2:0] col_zero;
  } job_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } qhead_t;

endpackage

// ----- rtl/amd_front.sv -----
`timescale 1ns / 1ps
module amd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  amd_pkg::in_t    matrix,
  input  logic            pop,
  output amd_pkg::qhead_t head
);

  amd_pkg::job_t slots [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       push;
  logic [2:0] zflags;

  assign busy = count[1];
  assign push = start && !busy;

  // classify columns that are all zero
  assign zflags[0] = (matrix.m00 == '0) && (matrix.m10 == '0) && (matrix.m20 == '0);
  assign zflags[1] = (matrix.m01 == '0) && (matrix.m11 == '0) && (matrix.m21 == '0);
  assign zflags[2] = (matrix.m02 == '0) && (matrix.m12 == '0) && (matrix.m22 == '0);

  assign head.valid = (count != 2'd0);
  assign head.job   = slots[rp];

  // two-entry queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= '{mat: matrix, col_zero: zflags};
    end
  end

endmodule

// ----- rtl/amd_sqrt.sv -----
`timescale 1ns / 1ps
module amd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [34:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [34:0] remsh;
  logic [34:0] trial;

  // one root bit per cycle, restoring
  assign remsh = {rem[32:0], rad[63:62]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'd32;
        run  <= 1'b1;
      end else if (run) begin
        if (remsh >= trial) begin
          rem  <= remsh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= remsh;
          root <= {root[30:0], 1'b0};
        end
        rad <= {rad[61:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/amd_div.sv -----
`timescale 1ns / 1ps
module amd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic               neg,
  input  logic [32:0]        mag,
  input  logic [32:0]        den,
  output logic               done,
  output logic signed [31:0] q
);

  logic [32:0] dreg;
  logic        nreg;
  logic        ovf;
  logic        zden;
  logic [32:0] rem;
  logic [32:0] dsh;
  logic [32:0] quot;
  logic [5:0]  cnt;
  logic        run;
  logic        fin;
  logic [33:0] remsh;
  logic [33:0] dext;
  logic [32:0] lim;
  logic [32:0] qmag;
  logic [32:0] qneg;

  // (mag * 2^30) / den, one quotient bit per cycle
  assign remsh = {rem, dsh[32]};
  assign dext  = {1'b0, dreg};

  // saturate to the signed 32-bit range
  assign lim  = nreg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign qmag = (ovf || (quot > lim)) ? lim : quot;
  assign qneg = ~qmag + 33'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        dreg <= den;
        nreg <= neg;
        ovf  <= ({3'b000, mag[32:3]} >= den);
        zden <= (den == '0);
        rem  <= {3'b000, mag[32:3]};
        dsh  <= {mag[2:0], 30'd0};
        quot <= '0;
        cnt  <= 6'd33;
        run  <= 1'b1;
      end else if (run) begin
        if (remsh >= dext) begin
          rem  <= 33'(remsh - dext);
          quot <= {quot[31:0], 1'b1};
        end else begin
          rem  <= remsh[32:0];
          quot <= {quot[31:0], 1'b0};
        end
        dsh <= {dsh[31:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (zden) begin
          q <= '0;
        end else if (nreg) begin
          q <= qneg[31:0];
        end else begin
          q <= qmag[31:0];
        end
      end
    end
  end

endmodule

// ----- rtl/amd_back.sv -----
`timescale 1ns / 1ps
module amd_back (
  input  logic            clk,
  input  logic            rst,
  input  amd_pkg::qhead_t head,
  output logic            pop,
  output logic            done,
  output amd_pkg::out_t   result
);

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic [4:0]         MUL_STEPS = 5'd21;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SQL, S_DIVR, S_TRACE, S_SQQ, S_DIVQ, S_OUT
  } state_t;

  state_t state;

  amd_pkg::in_t mat;
  logic [2:0]   zcol;

  logic [4:0]          idx;
  logic [4:0]          act_idx;
  logic                actv;
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  prod;
  logic [63:0]         sumsq [3];
  logic signed [63:0]  minor [3];
  logic signed [97:0]  det;

  logic [31:0]         len [3];
  logic signed [31:0]  r [3][3];
  logic [1:0]          ri;
  logic [1:0]          rj;
  logic                pend;

  logic                sq_go;
  logic [63:0]         sq_rad;
  logic                sq_done;
  logic [31:0]         sq_root;

  logic                dv_go;
  logic                dv_neg;
  logic [32:0]         dv_mag;
  logic [32:0]         dv_den;
  logic                dv_done;
  logic signed [31:0]  dv_q;

  logic signed [32:0]  num [4];
  logic [1:0]          diag;
  logic [1:0]          k;
  logic [32:0]         s_den;
  logic signed [31:0]  quat [4];

  logic signed [31:0]  el;
  logic [32:0]         el_mag;
  logic                el_neg;
  logic                r_fin;
  logic                q_fin;
  logic [32:0]         num_mag;

  logic signed [33:0]  tr;
  logic signed [34:0]  tv;
  logic [63:0]         trad;
  logic signed [32:0]  tn [4];
  logic [1:0]          tdiag;

  logic [30:0]         sc0;
  logic [30:0]         sc1;
  logic [30:0]         sc2;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
    sx33 = {x[31], x};
  endfunction

  assign pop = (state == S_IDLE) && head.valid;

  // shared multiplier operands for each step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (idx)
      5'd0:  begin mul_a = sx33(mat.m00); mul_b = sx33(mat.m00); end
      5'd1:  begin mul_a = sx33(mat.m10); mul_b = sx33(mat.m10); end
      5'd2:  begin mul_a = sx33(mat.m20); mul_b = sx33(mat.m20); end
      5'd3:  begin mul_a = sx33(mat.m01); mul_b = sx33(mat.m01); end
      5'd4:  begin mul_a = sx33(mat.m11); mul_b = sx33(mat.m11); end
      5'd5:  begin mul_a = sx33(mat.m21); mul_b = sx33(mat.m21); end
      5'd6:  begin mul_a = sx33(mat.m02); mul_b = sx33(mat.m02); end
      5'd7:  begin mul_a = sx33(mat.m12); mul_b = sx33(mat.m12); end
      5'd8:  begin mul_a = sx33(mat.m22); mul_b = sx33(mat.m22); end
      5'd9:  begin mul_a = sx33(mat.m11); mul_b = sx33(mat.m22); end
      5'd10: begin mul_a = sx33(mat.m21); mul_b = sx33(mat.m12); end
      5'd11: begin mul_a = sx33(mat.m10); mul_b = sx33(mat.m22); end
      5'd12: begin mul_a = sx33(mat.m20); mul_b = sx33(mat.m12); end
      5'd13: begin mul_a = sx33(mat.m10); mul_b = sx33(mat.m21); end
      5'd14: begin mul_a = sx33(mat.m20); mul_b = sx33(mat.m11); end
      5'd15: begin mul_a = sx33(minor[0][63:32]); mul_b = sx33(mat.m00); end
      5'd16: begin mul_a = {1'b0, minor[0][31:0]}; mul_b = sx33(mat.m00); end
      5'd17: begin mul_a = sx33(minor[1][63:32]); mul_b = -sx33(mat.m01); end
      5'd18: begin mul_a = {1'b0, minor[1][31:0]}; mul_b = -sx33(mat.m01); end
      5'd19: begin mul_a = sx33(minor[2][63:32]); mul_b = sx33(mat.m02); end
      5'd20: begin mul_a = {1'b0, minor[2][31:0]}; mul_b = sx33(mat.m02); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // matrix entry for the normalizing divide
  always_comb begin
    case ({ri, rj})
      4'b0000: el = mat.m00;
      4'b0001: el = mat.m01;
      4'b0010: el = mat.m02;
      4'b0100: el = mat.m10;
      4'b0101: el = mat.m11;
      4'b0110: el = mat.m12;
      4'b1000: el = mat.m20;
      4'b1001: el = mat.m21;
      4'b1010: el = mat.m22;
      default: el = '0;
    endcase
  end

  assign el_mag  = el[31] ? 33'(-sx33(el)) : {1'b0, el};
  assign el_neg  = el[31] ^ ((rj == 2'd0) && det[97]);
  assign r_fin   = pend ? zcol[rj] : dv_done;
  assign q_fin   = pend ? (k == diag) : dv_done;
  assign num_mag = num[k][32] ? 33'(-num[k]) : num[k];

  // trace branch selection
  always_comb begin
    tr = 34'(r[0][0]) + 34'(r[1][1]) + 34'(r[2][2]);
    if (tr > 34'sd0) begin
      tdiag = 2'd3;
      tv    = 35'(tr) + 35'(ONE_Q30);
      tn[0] = sx33(r[2][1]) - sx33(r[1][2]);
      tn[1] = sx33(r[0][2]) - sx33(r[2][0]);
      tn[2] = sx33(r[1][0]) - sx33(r[0][1]);
      tn[3] = '0;
    end else if ((r[0][0] > r[1][1]) && (r[0][0] > r[2][2])) begin
      tdiag = 2'd0;
      tv    = 35'(ONE_Q30) + 35'(r[0][0]) - 35'(r[1][1]) - 35'(r[2][2]);
      tn[0] = '0;
      tn[1] = sx33(r[0][1]) + sx33(r[1][0]);
      tn[2] = sx33(r[0][2]) + sx33(r[2][0]);
      tn[3] = sx33(r[2][1]) - sx33(r[1][2]);
    end else if (r[1][1] > r[2][2]) begin
      tdiag = 2'd1;
      tv    = 35'(ONE_Q30) + 35'(r[1][1]) - 35'(r[0][0]) - 35'(r[2][2]);
      tn[0] = sx33(r[0][1]) + sx33(r[1][0]);
      tn[1] = '0;
      tn[2] = sx33(r[1][2]) + sx33(r[2][1]);
      tn[3] = sx33(r[0][2]) - sx33(r[2][0]);
    end else begin
      tdiag = 2'd2;
      tv    = 35'(ONE_Q30) + 35'(r[2][2]) - 35'(r[0][0]) - 35'(r[1][1]);
      tn[0] = sx33(r[0][2]) + sx33(r[2][0]);
      tn[1] = sx33(r[1][2]) + sx33(r[2][1]);
      tn[2] = '0;
      tn[3] = sx33(r[1][0]) - sx33(r[0][1]);
    end
    trad = (tv > 35'sd0) ? {tv[33:0], 30'd0} : '0;
  end

  // saturated scales
  assign sc0 = len[0][31] ? 31'h7FFF_FFFF : len[0][30:0];
  assign sc1 = len[1][31] ? 31'h7FFF_FFFF : len[1][30:0];
  assign sc2 = len[2][31] ? 31'h7FFF_FFFF : len[2][30:0];

  amd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sq_go),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  amd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (dv_go),
    .neg  (dv_neg),
    .mag  (dv_mag),
    .den  (dv_den),
    .done (dv_done),
    .q    (dv_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      actv  <= 1'b0;
      idx   <= '0;
      pend  <= 1'b0;
      sq_go <= 1'b0;
      dv_go <= 1'b0;
      done  <= 1'b0;
    end else begin
      sq_go <= 1'b0;
      dv_go <= 1'b0;
      done  <= 1'b0;

      // retire last multiplier product
      if (actv) begin
        case (act_idx)
          5'd0, 5'd1, 5'd2: sumsq[0] <= sumsq[0] + prod[63:0];
          5'd3, 5'd4, 5'd5: sumsq[1] <= sumsq[1] + prod[63:0];
          5'd6, 5'd7, 5'd8: sumsq[2] <= sumsq[2] + prod[63:0];
          5'd9:  minor[0] <= prod[63:0];
          5'd10: minor[0] <= minor[0] - prod[63:0];
          5'd11: minor[1] <= prod[63:0];
          5'd12: minor[1] <= minor[1] - prod[63:0];
          5'd13: minor[2] <= prod[63:0];
          5'd14: minor[2] <= minor[2] - prod[63:0];
          5'd15, 5'd17, 5'd19: det <= det + {prod, 32'd0};
          5'd16, 5'd18, 5'd20: det <= det + {{32{prod[65]}}, prod};
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (head.valid) begin
            mat      <= head.job.mat;
            zcol     <= head.job.col_zero;
            sumsq[0] <= '0;
            sumsq[1] <= '0;
            sumsq[2] <= '0;
            det      <= '0;
            idx      <= '0;
            state    <= S_MUL;
          end
        end

        S_MUL: begin
          if (idx != MUL_STEPS) begin
            prod    <= mul_a * mul_b;
            act_idx <= idx;
            actv    <= 1'b1;
            idx     <= idx + 5'd1;
          end else begin
            actv   <= 1'b0;
            sq_rad <= sumsq[0];
            sq_go  <= 1'b1;
            rj     <= 2'd0;
            state  <= S_SQL;
          end
        end

        // column lengths
        S_SQL: begin
          if (sq_done) begin
            len[rj] <= sq_root;
            if (rj == 2'd2) begin
              rj    <= 2'd0;
              ri    <= 2'd0;
              pend  <= 1'b1;
              state <= S_DIVR;
            end else begin
              rj     <= rj + 2'd1;
              sq_rad <= sumsq[rj + 2'd1];
              sq_go  <= 1'b1;
            end
          end
        end

        // normalized rotation entries
        S_DIVR: begin
          if (pend && !zcol[rj]) begin
            dv_go  <= 1'b1;
            dv_mag <= el_mag;
            dv_neg <= el_neg;
            dv_den <= {1'b0, len[rj]};
            pend   <= 1'b0;
          end
          if (r_fin) begin
            if (pend) begin
              r[ri][rj] <= (ri == rj) ? ONE_Q30 : '0;
            end else begin
              r[ri][rj] <= dv_q;
            end
            pend <= 1'b1;
            if (ri == 2'd2) begin
              ri <= 2'd0;
              if (rj == 2'd2) begin
                state <= S_TRACE;
              end else begin
                rj <= rj + 2'd1;
              end
            end else begin
              ri <= ri + 2'd1;
            end
          end
        end

        S_TRACE: begin
          num[0] <= tn[0];
          num[1] <= tn[1];
          num[2] <= tn[2];
          num[3] <= tn[3];
          diag   <= tdiag;
          sq_rad <= trad;
          sq_go  <= 1'b1;
          state  <= S_SQQ;
        end

        S_SQQ: begin
          if (sq_done) begin
            quat[diag] <= {1'b0, sq_root[31:1]};
            s_den      <= {sq_root, 1'b0};
            k          <= 2'd0;
            pend       <= 1'b1;
            state      <= S_DIVQ;
          end
        end

        // off-diagonal quaternion components
        S_DIVQ: begin
          if (pend && (k != diag)) begin
            dv_go  <= 1'b1;
            dv_mag <= num_mag;
            dv_neg <= num[k][32];
            dv_den <= s_den;
            pend   <= 1'b0;
          end
          if (q_fin) begin
            if (!pend) begin
              quat[k] <= dv_q;
            end
            pend <= 1'b1;
            if (k == 2'd3) begin
              state <= S_OUT;
            end else begin
              k <= k + 2'd1;
            end
          end
        end

        S_OUT: begin
          result.pos_x   <= mat.m03;
          result.pos_y   <= mat.m13;
          result.pos_z   <= mat.m23;
          result.scale_x <= det[97] ? -{1'b0, sc0} : {1'b0, sc0};
          result.scale_y <= sc1;
          result.scale_z <= sc2;
          result.rot_x   <= quat[0];
          result.rot_y   <= quat[1];
          result.rot_z   <= quat[2];
          result.rot_w   <= quat[3];
          done           <= 1'b1;
          pend           <= 1'b0;
          state          <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/affine_matrix_decompose_core.sv -----
`timescale 1ns / 1ps
// Splits an affine matrix word (upper three rows, Q16.16) into translation,
// column scales and a Q2.30 quaternion. A word is taken when start is high
// and busy is low; two words can wait in the input queue while the engine
// works. Each result appears on result for a single cycle with done high
// and must be captured then, since the block cannot be held off. The engine
// handles one matrix at a time and takes the next queued one when it returns
// to idle. Its work is 21 multiplies on one shared multiplier, four square
// roots at one root bit per cycle and twelve divides at one quotient bit per
// cycle; an all-zero column skips its three divides.
module affine_matrix_decompose_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  amd_pkg::in_t  matrix,
  output logic          done,
  output amd_pkg::out_t result
);

  amd_pkg::qhead_t head;
  logic            pop;

  amd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .matrix (matrix),
    .pop    (pop),
    .head   (head)
  );

  amd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

  // done strobes never come back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe held two cycles");

  // engine only takes a queued word
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");

  // a full queue has a word at its head
  a_busy_valid: assert property (@(posedge clk) disable iff (rst) busy |-> head.valid)
    else $error("busy with empty queue");

  // an accepted word is visible next cycle
  a_accept_seen: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> head.valid)
    else $error("accepted word lost");

endmodule

// ----- verif/affine_matrix_decompose_core_tb.sv -----
`timescale 1ns / 1ps
module affine_matrix_decompose_core_tb;

  localparam int NUM_RANDOM = 1130;
  localparam logic signed [63:0] Q30_ONE = 64'sd1 << 30;

  // integer square root, floor
  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // (num * 2^30) / den toward zero, clipped to 32 bits signed
  function automatic logic signed [63:0] frac_div(input logic signed [63:0] num,
                                                  input logic [63:0] den);
    logic [63:0] mag, quo;
    logic neg;
    if (den == 0) return 0;
    neg = num < 0;
    mag = neg ? -num : num;
    quo = (mag << 30) / den;
    if (neg) begin
      if (quo > 64'h8000_0000) quo = 64'h8000_0000;
      return -$signed(quo);
    end
    if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
    return $signed(quo);
  endfunction

  // translation, column scales and quaternion of one matrix
  function automatic amd_pkg::out_t decompose(input amd_pkg::in_t w);
    logic signed [63:0] m[3][4];
    logic signed [63:0] r[3][3];
    logic [63:0] len[3], sc[3], sum, root, s;
    logic signed [63:0] q[4], tr, v;
    logic signed [127:0] det;
    logic neg_det;
    amd_pkg::out_t o;
    m[0][0] = w.m00; m[0][1] = w.m01; m[0][2] = w.m02; m[0][3] = w.m03;
    m[1][0] = w.m10; m[1][1] = w.m11; m[1][2] = w.m12; m[1][3] = w.m13;
    m[2][0] = w.m20; m[2][1] = w.m21; m[2][2] = w.m22; m[2][3] = w.m23;
    for (int j = 0; j < 3; j++) begin
      sum = 0;
      for (int i = 0; i < 3; i++) sum = sum + m[i][j] * m[i][j];
      len[j] = isqrt(sum);
      sc[j] = len[j] > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : len[j];
    end
    det = 128'(m[0][0]) * (128'(m[1][1]) * m[2][2] - 128'(m[2][1]) * m[1][2])
        - 128'(m[0][1]) * (128'(m[1][0]) * m[2][2] - 128'(m[2][0]) * m[1][2])
        + 128'(m[0][2]) * (128'(m[1][0]) * m[2][1] - 128'(m[2][0]) * m[1][1]);
    neg_det = det < 0;
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) begin
        if (len[j] == 0) r[i][j] = (i == j) ? Q30_ONE : 0;
        else r[i][j] = frac_div(m[i][j], len[j]);
        if (j == 0 && neg_det && len[0] != 0) r[i][j] = -r[i][j];
      end
    // four-branch trace method
    tr = r[0][0] + r[1][1] + r[2][2];
    if (tr > 0) begin
      v = tr + Q30_ONE;
      root = isqrt(v << 30);
      s = root * 2;
      q[3] = root >> 1;
      q[0] = frac_div(r[2][1] - r[1][2], s);
      q[1] = frac_div(r[0][2] - r[2][0], s);
      q[2] = frac_div(r[1][0] - r[0][1], s);
    end else if (r[0][0] > r[1][1] && r[0][0] > r[2][2]) begin
      v = Q30_ONE + r[0][0] - r[1][1] - r[2][2];
      root = v > 0 ? isqrt(v << 30) : 0;
      s = root * 2;
      q[3] = frac_div(r[2][1] - r[1][2], s);
      q[0] = root >> 1;
      q[1] = frac_div(r[0][1] + r[1][0], s);
      q[2] = frac_div(r[0][2] + r[2][0], s);
    end else if (r[1][1] > r[2][2]) begin
      v = Q30_ONE + r[1][1] - r[0][0] - r[2][2];
      root = v > 0 ? isqrt(v << 30) : 0;
      s = root * 2;
      q[3] = frac_div(r[0][2] - r[2][0], s);
      q[0] = frac_div(r[0][1] + r[1][0], s);
      q[1] = root >> 1;
      q[2] = frac_div(r[1][2] + r[2][1], s);
    end else begin
      v = Q30_ONE + r[2][2] - r[0][0] - r[1][1];
      root = v > 0 ? isqrt(v << 30) : 0;
      s = root * 2;
      q[3] = frac_div(r[1][0] - r[0][1], s);
      q[0] = frac_div(r[0][2] + r[2][0], s);
      q[1] = frac_div(r[1][2] + r[2][1], s);
      q[2] = root >> 1;
    end
    o.pos_x = w.m03;
    o.pos_y = w.m13;
    o.pos_z = w.m23;
    o.scale_x = neg_det ? -sc[0][31:0] : sc[0][31:0];
    o.scale_y = sc[1][30:0];
    o.scale_z = sc[2][30:0];
    o.rot_x = q[0][31:0];
    o.rot_y = q[1][31:0];
    o.rot_z = q[2][31:0];
    o.rot_w = q[3][31:0];
    return o;
  endfunction

  class decomp_scoreboard;
    amd_pkg::out_t pending[$];
    int errors;

    function void note_matrix(amd_pkg::in_t w);
      pending.push_back(decompose(w));
    endfunction

    function void check_result(amd_pkg::out_t got);
      amd_pkg::out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp.pos_x !== got.pos_x)
        $display("%0t: pos_x exp %h got %h", $time, exp.pos_x, got.pos_x);
      if (exp.pos_y !== got.pos_y)
        $display("%0t: pos_y exp %h got %h", $time, exp.pos_y, got.pos_y);
      if (exp.pos_z !== got.pos_z)
        $display("%0t: pos_z exp %h got %h", $time, exp.pos_z, got.pos_z);
      if (exp.scale_x !== got.scale_x)
        $display("%0t: scale_x exp %h got %h", $time, exp.scale_x, got.scale_x);
      if (exp.scale_y !== got.scale_y)
        $display("%0t: scale_y exp %h got %h", $time, exp.scale_y, got.scale_y);
      if (exp.scale_z !== got.scale_z)
        $display("%0t: scale_z exp %h got %h", $time, exp.scale_z, got.scale_z);
      if (exp.rot_x !== got.rot_x)
        $display("%0t: rot_x exp %h got %h", $time, exp.rot_x, got.rot_x);
      if (exp.rot_y !== got.rot_y)
        $display("%0t: rot_y exp %h got %h", $time, exp.rot_y, got.rot_y);
      if (exp.rot_z !== got.rot_z)
        $display("%0t: rot_z exp %h got %h", $time, exp.rot_z, got.rot_z);
      if (exp.rot_w !== got.rot_w)
        $display("%0t: rot_w exp %h got %h", $time, exp.rot_w, got.rot_w);
      if (exp !== got) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  amd_pkg::in_t matrix = '0;
  amd_pkg::out_t result;
  decomp_scoreboard sb = new();

  affine_matrix_decompose_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .matrix(matrix), .done(done), .result(result)
  );

  always #4 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // hand one word to the block, with a random gap first; start stays high
  // between words when the gap is zero
  task automatic send_matrix(input amd_pkg::in_t w);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    matrix <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_matrix(w);
    @(negedge clk);
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_entry(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 8) == 0 ? 32'h0 : $signed($urandom_range(0, 262143)) - 131072;
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return ($urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000);
    endcase
  endfunction

  // mostly plausible transforms, some raw noise
  function automatic amd_pkg::in_t rand_matrix();
    amd_pkg::in_t w;
    logic [31:0] e[12];
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) begin
      if (kind < 6) e[k] = rand_entry(1);
      else if (kind < 8) e[k] = rand_entry(0);
      else e[k] = rand_entry($urandom_range(0, 3));
    end
    // occasionally clear a whole column
    if ($urandom_range(0, 9) == 0) begin
      int c;
      c = $urandom_range(0, 2);
      e[c] = 0; e[4 + c] = 0; e[8 + c] = 0;
    end
    w = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], e[9], e[10], e[11]};
    return w;
  endfunction

  function automatic amd_pkg::in_t diag(input logic [31:0] a, b, c);
    amd_pkg::in_t w;
    w = '0;
    w.m00 = a; w.m11 = b; w.m22 = c;
    w.m03 = 32'h7FFF_FFFF; w.m13 = 32'h8000_0000; w.m23 = 32'hFFFF_FFFF;
    return w;
  endfunction

  initial begin
    amd_pkg::in_t w;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: identity, zeros, mirror, each trace branch, extremes
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix('0);
    send_matrix(diag(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000));
    send_matrix(diag(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000));
    send_matrix(diag(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h0, 32'h0002_0000, 32'h0));
    send_matrix({12{32'h8000_0000}});
    send_matrix({12{32'h7FFF_FFFF}});
    send_matrix({12{32'hFFFF_FFFF}});
    // 90 degree rotation about z, scale 2
    w = '0;
    w.m01 = 32'hFFFE_0000; w.m10 = 32'h0002_0000; w.m22 = 32'h0002_0000;
    send_matrix(w);
    // wait until the queue has drained
    drain();
    for (int n = 0; n < NUM_RANDOM; n++) begin
      send_matrix(rand_matrix());
      if (n == NUM_RANDOM / 2)
        drain();
    end
    drain();
    repeat (700) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
